### src/rfm_pkg.sv
// Shared types and constants for the reciprocal frequency meter.
// Holds the register map, reset values and the structs passed between modules.
// No dependencies.
`default_nettype none

package rfm_pkg;

  localparam int TIMER_BITS_DEF = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ZERO_TIMEOUT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOW_TIMEOUT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 2'd2;

  localparam logic [31:0] ZERO_TIMEOUT_RST   = 32'd1872000;
  localparam logic [31:0] NOW_TIMEOUT_RST    = 32'd374400;
  localparam logic [15:0] DEBOUNCE_TICKS_RST = 16'd180;

  typedef struct packed {
    logic [31:0] zero_timeout;
    logic [31:0] now_timeout;
    logic [15:0] debounce_ticks;
  } cfg_t;

  typedef struct packed {
    logic        overflow_event;
    logic        capture_event;
    logic [15:0] counter_value;
    logic [15:0] capture_value;
  } item_t;

  typedef struct packed {
    logic [31:0] period_ticks;
    logic [15:0] pulses;
    logic        closed_by_timeout;
  } result_t;

endpackage

`default_nettype wire

### src/reciprocal_frequency_meter_top.sv
// Top level of the reciprocal frequency meter: input register, event update, result register.
// Depends on rfm_pkg, rfm_cfg_regs and rfm_core.
//
// Usage:
//   s_* channel carries one timer event per request: s_tuser holds the overflow
//   and capture flags, s_tdata the free-running counter value and the captured
//   edge time. m_* channel carries one closed measurement per request: window
//   length in ticks, debounced pulse count, and whether the overflow timeout
//   closed it. Most events produce no result.
//   An accepted request is held in the input register; the event update then
//   runs combinationally into the result register, so a result shows on m_*
//   once it has passed both registers. One request is taken every cycle
//   while the receiver does not stall.
//   When the receiver stalls, the result register holds and the input register
//   fills; s_tready drops once both are occupied, and rises again as soon as
//   the result is taken.
//   Reset (rst, synchronous) clears the measurement state, empties both
//   registers and restores the configuration defaults. Write cfg_* only while
//   the block is idle.
`default_nettype none

module reciprocal_frequency_meter_top #(
  parameter int TIMER_BITS = rfm_pkg::TIMER_BITS_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  // s_tdata: counter_value[15:0], capture_value[31:16]
  input  wire  [31:0]                     s_tdata,
  // s_tuser: overflow_event[0], capture_event[1]
  input  wire  [1:0]                      s_tuser,
  input  wire                             s_tvalid,
  output logic                            s_tready,
  // m_tdata: period_ticks[31:0], pulses[47:32]
  output logic [47:0]                     m_tdata,
  // m_tuser: closed_by_timeout[0]
  output logic [0:0]                      m_tuser,
  output logic                            m_tvalid,
  input  wire                             m_tready,
  input  wire                             cfg_we,
  input  wire  [rfm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [rfm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import rfm_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  logic    advance;
  logic    res_valid;
  result_t res;

  rfm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.overflow_event <= s_tuser[0];
      in_item.capture_event  <= s_tuser[1];
      in_item.counter_value  <= s_tdata[15:0];
      in_item.capture_value  <= s_tdata[31:16];
    end
  end

  rfm_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .item      (in_item),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      m_tdata <= {res.pulses, res.period_ticks};
      m_tuser <= res.closed_by_timeout;
    end
  end

endmodule

`default_nettype wire

### src/rfm_cfg_regs.sv
// Configuration register file of the reciprocal frequency meter.
// Depends on rfm_pkg for the register map and reset values.
`default_nettype none

module rfm_cfg_regs (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_we,
  input  wire  [rfm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [rfm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output rfm_pkg::cfg_t                   cfg
);
  import rfm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.zero_timeout   <= ZERO_TIMEOUT_RST;
      cfg.now_timeout    <= NOW_TIMEOUT_RST;
      cfg.debounce_ticks <= DEBOUNCE_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ZERO_TIMEOUT:   cfg.zero_timeout   <= cfg_wdata;
        REG_NOW_TIMEOUT:    cfg.now_timeout    <= cfg_wdata;
        REG_DEBOUNCE_TICKS: cfg.debounce_ticks <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### src/rfm_core.sv
// Measurement state and combinational event update of the frequency meter.
// Depends on rfm_pkg for the item, result and configuration structs.
`default_nettype none

module rfm_core #(
  parameter int TIMER_BITS = rfm_pkg::TIMER_BITS_DEF
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                step,
  input  wire rfm_pkg::item_t item,
  input  wire rfm_pkg::cfg_t  cfg,
  output logic               res_valid,
  output rfm_pkg::result_t   res
);
  import rfm_pkg::*;

  localparam int VAL_W = (TIMER_BITS < 16) ? TIMER_BITS : 16;
  localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  logic [15:0]      overflow_count;
  logic [31:0]      window_start;
  logic [15:0]      pulse_count;
  logic [VAL_W-1:0] last_capture;
  logic             armed;

  logic [15:0]      overflow_count_next;
  logic [31:0]      window_start_next;
  logic [15:0]      pulse_count_next;
  logic [VAL_W-1:0] last_capture_next;
  logic             armed_next;

  logic [VAL_W-1:0]      cnt_m;
  logic [VAL_W-1:0]      cap_m;
  logic [15:0]           oc_inc;
  logic [31:0]           now_ovf;
  logic [31:0]           age;
  logic                  close_ovf;
  logic                  arm_ovf;
  logic                  armed_mid;
  logic [31:0]           ws_mid;
  logic [15:0]           pc_mid;
  logic [15:0]           oc_mid;
  logic [TIMER_BITS-1:0] gap;
  logic                  counted;
  logic [15:0]           pc_cap;
  logic                  close_cap;
  logic [31:0]           now_cap;

  // Time base: overflow count above the timer bits, mod 2^32.
  function automatic logic [31:0] ext_time(input logic [15:0] oc, input logic [VAL_W-1:0] v);
    logic [47:0] t;
    t = (48'(oc) << TIMER_BITS) + 48'(v);
    return t[31:0];
  endfunction

  always_comb begin
    cnt_m  = item.counter_value[VAL_W-1:0];
    cap_m  = item.capture_value[VAL_W-1:0];

    // Overflow part runs first.
    oc_inc    = overflow_count + 16'd1;
    now_ovf   = ext_time(oc_inc, cnt_m);
    age       = now_ovf - window_start;
    close_ovf = item.overflow_event && (age > cfg.zero_timeout);
    arm_ovf   = item.overflow_event && !close_ovf && (age > cfg.now_timeout)
                && (pulse_count != 16'd0);

    armed_mid = item.overflow_event ? arm_ovf : armed;
    ws_mid    = close_ovf ? now_ovf : window_start;
    pc_mid    = close_ovf ? 16'd0 : pulse_count;
    oc_mid    = item.overflow_event ? oc_inc : overflow_count;

    // Capture part: debounce on the wrapped gap.
    gap       = TIMER_BITS'(cap_m) - TIMER_BITS'(last_capture);
    counted   = item.capture_event && (CMP_W'(gap) > CMP_W'(cfg.debounce_ticks));
    pc_cap    = counted ? pc_mid + 16'd1 : pc_mid;
    close_cap = counted && armed_mid;
    now_cap   = ext_time(oc_mid, cap_m);

    overflow_count_next = oc_mid;
    armed_next          = close_cap ? 1'b0 : armed_mid;
    window_start_next   = close_cap ? now_cap : ws_mid;
    pulse_count_next    = close_cap ? 16'd0 : pc_cap;
    last_capture_next   = item.capture_event ? cap_m : last_capture;

    res_valid = close_ovf || close_cap;
    if (close_ovf) begin
      res.period_ticks      = age;
      res.pulses            = pulse_count;
      res.closed_by_timeout = 1'b1;
    end else begin
      res.period_ticks      = now_cap - ws_mid;
      res.pulses            = pc_cap;
      res.closed_by_timeout = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_count <= '0;
      window_start   <= '0;
      pulse_count    <= '0;
      last_capture   <= '0;
      armed          <= 1'b0;
    end else if (step) begin
      overflow_count <= overflow_count_next;
      window_start   <= window_start_next;
      pulse_count    <= pulse_count_next;
      last_capture   <= last_capture_next;
      armed          <= armed_next;
    end
  end

endmodule

`default_nettype wire

### src/rfm_checker.sv
// Port-level checks for the reciprocal frequency meter, bound to the top level.
// Depends only on the top-level ports.
`default_nettype none

module rfm_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire [47:0] m_tdata,
  input wire [0:0]  m_tuser,
  input wire        m_tvalid,
  input wire        m_tready
);

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // Reset empties both registers.
  assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("registers not empty after reset");

  // A fresh result comes from a request taken earlier through the input register.
  assert property (@(posedge clk) disable iff (rst)
    !m_tvalid ##1 m_tvalid |-> $past(s_tvalid && s_tready, 2))
    else $error("result without matching request");

  // With the result register free, the input side never blocks.
  assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty result register");

endmodule

bind reciprocal_frequency_meter_top rfm_checker u_rfm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

`default_nettype wire
